// ===== design/assert_macros.svh =====
// Assertion macros shared by the face normal design.
// No dependencies; the including module must provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, disabled while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every rising clock edge, disabled while reset is high.
`define ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

// ===== design/tfn_pkg.sv =====
// Shared widths and pipeline token types for the triangle face normal unit.
// No dependencies.
`default_nettype none

package tfn_pkg;

  localparam int POS_W     = 32;                 // corner coordinate, Q16.16
  localparam int EDGE_W    = POS_W + 1;          // edge vector component
  localparam int PROD_W    = 2 * EDGE_W;         // one signed edge product
  localparam int CROSS_W   = PROD_W + 1;         // signed cross component
  localparam int MAG_W     = PROD_W;             // cross magnitude
  localparam int HALF_W    = MAG_W / 2;          // limb for squaring
  localparam int PART_W    = 2 * HALF_W;         // one limb product
  localparam int SQ_W      = 2 * MAG_W;          // squared magnitude and sum
  localparam int REM_W     = SQ_W + 1;           // division remainder
  localparam int QUO_W     = 31;                 // floor(2^30 m^2 / S) <= 2^30
  localparam int ROOT_W    = 16;                 // isqrt of the quotient <= 2^15
  localparam int SQ_REM_W  = QUO_W;              // square root remainder
  localparam int TRIAL_W   = 2 * ROOT_W + 2;     // square root trial value
  localparam int NORM_W    = 16;                 // Q1.14 normal component
  localparam int LANES     = 3;

  // Lane of the division chain.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  // Request traveling through the division chain.
  typedef struct packed {
    logic                   valid;
    logic                   degen;
    logic [LANES-1:0]       neg;
    logic [SQ_W-1:0]        sum_sq;
    div_lane_t [LANES-1:0]  lane;
  } div_tok_t;

  // Lane of the square root chain.
  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sqrt_lane_t;

  // Request traveling through the square root chain.
  typedef struct packed {
    logic                   valid;
    logic                   degen;
    logic [LANES-1:0]       neg;
    sqrt_lane_t [LANES-1:0] lane;
  } sqrt_tok_t;

endpackage

`default_nettype wire

// ===== design/tfn_front.sv =====
// Front end: edge vectors, exact cross product, squared magnitudes and their sum.
// Depends on tfn_pkg.
`default_nettype none

module tfn_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             en,
  input  wire logic                             valid_in,
  input  wire logic signed [tfn_pkg::POS_W-1:0] corner0_x,
  input  wire logic signed [tfn_pkg::POS_W-1:0] corner0_y,
  input  wire logic signed [tfn_pkg::POS_W-1:0] corner0_z,
  input  wire logic signed [tfn_pkg::POS_W-1:0] corner1_x,
  input  wire logic signed [tfn_pkg::POS_W-1:0] corner1_y,
  input  wire logic signed [tfn_pkg::POS_W-1:0] corner1_z,
  input  wire logic signed [tfn_pkg::POS_W-1:0] corner2_x,
  input  wire logic signed [tfn_pkg::POS_W-1:0] corner2_y,
  input  wire logic signed [tfn_pkg::POS_W-1:0] corner2_z,
  output tfn_pkg::div_tok_t                     tok_out
);

  logic                                valid_a, valid_b, valid_c, valid_d, valid_e;
  logic signed [tfn_pkg::EDGE_W-1:0]   vec_a [3];
  logic signed [tfn_pkg::EDGE_W-1:0]   vec_b [3];
  logic signed [tfn_pkg::PROD_W-1:0]   prod [6];
  logic signed [tfn_pkg::CROSS_W-1:0]  cross_next [3];
  logic signed [tfn_pkg::CROSS_W-1:0]  abs_next [3];
  logic [tfn_pkg::MAG_W-1:0]           mag [3];
  logic [2:0]                          neg_c, neg_d, neg_e;
  logic [tfn_pkg::PART_W-1:0]          p_ll [3];
  logic [tfn_pkg::PART_W-1:0]          p_lh [3];
  logic [tfn_pkg::PART_W-1:0]          p_hh [3];
  logic [tfn_pkg::SQ_W-1:0]            sq [3];
  tfn_pkg::div_tok_t                   tok_next;

  // Valid pipeline of the front stages ahead of the output token.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a       <= 1'b0;
      valid_b       <= 1'b0;
      valid_c       <= 1'b0;
      valid_d       <= 1'b0;
      valid_e       <= 1'b0;
    end else if (en) begin
      valid_a       <= valid_in;
      valid_b       <= valid_a;
      valid_c       <= valid_b;
      valid_d       <= valid_c;
      valid_e       <= valid_d;
    end
  end

  // Edge vectors leaving the pivot corner.
  always_ff @(posedge clk) begin
    if (en) begin
      vec_a[0] <= tfn_pkg::EDGE_W'(corner2_x) - tfn_pkg::EDGE_W'(corner1_x);
      vec_a[1] <= tfn_pkg::EDGE_W'(corner2_y) - tfn_pkg::EDGE_W'(corner1_y);
      vec_a[2] <= tfn_pkg::EDGE_W'(corner2_z) - tfn_pkg::EDGE_W'(corner1_z);
      vec_b[0] <= tfn_pkg::EDGE_W'(corner0_x) - tfn_pkg::EDGE_W'(corner1_x);
      vec_b[1] <= tfn_pkg::EDGE_W'(corner0_y) - tfn_pkg::EDGE_W'(corner1_y);
      vec_b[2] <= tfn_pkg::EDGE_W'(corner0_z) - tfn_pkg::EDGE_W'(corner1_z);
    end
  end

  // Six signed edge products, one multiplier each.
  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= tfn_pkg::PROD_W'(vec_a[1]) * tfn_pkg::PROD_W'(vec_b[2]);
      prod[1] <= tfn_pkg::PROD_W'(vec_a[2]) * tfn_pkg::PROD_W'(vec_b[1]);
      prod[2] <= tfn_pkg::PROD_W'(vec_a[2]) * tfn_pkg::PROD_W'(vec_b[0]);
      prod[3] <= tfn_pkg::PROD_W'(vec_a[0]) * tfn_pkg::PROD_W'(vec_b[2]);
      prod[4] <= tfn_pkg::PROD_W'(vec_a[0]) * tfn_pkg::PROD_W'(vec_b[1]);
      prod[5] <= tfn_pkg::PROD_W'(vec_a[1]) * tfn_pkg::PROD_W'(vec_b[0]);
    end
  end

  // Cross components as sign and magnitude.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cross_next[i] = tfn_pkg::CROSS_W'(prod[2*i]) - tfn_pkg::CROSS_W'(prod[2*i+1]);
      abs_next[i]   = cross_next[i][tfn_pkg::CROSS_W-1] ? -cross_next[i] : cross_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg_c[i] <= cross_next[i][tfn_pkg::CROSS_W-1];
        mag[i]   <= abs_next[i][tfn_pkg::MAG_W-1:0];
      end
    end
  end

  // Limb products for squaring each magnitude.
  always_ff @(posedge clk) begin
    if (en) begin
      neg_d <= neg_c;
      for (int i = 0; i < 3; i++) begin
        p_ll[i] <= tfn_pkg::PART_W'(mag[i][tfn_pkg::HALF_W-1:0])
                 * tfn_pkg::PART_W'(mag[i][tfn_pkg::HALF_W-1:0]);
        p_lh[i] <= tfn_pkg::PART_W'(mag[i][tfn_pkg::HALF_W-1:0])
                 * tfn_pkg::PART_W'(mag[i][tfn_pkg::MAG_W-1:tfn_pkg::HALF_W]);
        p_hh[i] <= tfn_pkg::PART_W'(mag[i][tfn_pkg::MAG_W-1:tfn_pkg::HALF_W])
                 * tfn_pkg::PART_W'(mag[i][tfn_pkg::MAG_W-1:tfn_pkg::HALF_W]);
      end
    end
  end

  // Squared magnitudes assembled from the limb products.
  always_ff @(posedge clk) begin
    if (en) begin
      neg_e <= neg_d;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= (tfn_pkg::SQ_W'(p_hh[i]) << (2 * tfn_pkg::HALF_W))
               + (tfn_pkg::SQ_W'(p_lh[i]) << (tfn_pkg::HALF_W + 1))
               + tfn_pkg::SQ_W'(p_ll[i]);
      end
    end
  end

  // Squared length and the division start values.
  always_comb begin
    tok_next        = tok_out;
    tok_next.valid  = valid_e;
    tok_next.neg    = neg_e;
    tok_next.degen  = (sq[0] == '0) && (sq[1] == '0) && (sq[2] == '0);
    tok_next.sum_sq = sq[0] + sq[1] + sq[2];
    for (int i = 0; i < 3; i++) begin
      tok_next.lane[i].rem = tfn_pkg::REM_W'(sq[i]);
      tok_next.lane[i].quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/tfn_div_cell.sv =====
// One restoring division step for all three lanes: one quotient bit per cell.
// Depends on tfn_pkg.
`default_nettype none

module tfn_div_cell (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  tfn_pkg::div_tok_t tok_in,
  output tfn_pkg::div_tok_t tok_out
);

  tfn_pkg::div_tok_t            tok_next;
  logic [tfn_pkg::REM_W-1:0]    diff;
  logic [tfn_pkg::REM_W-1:0]    kept;
  logic                         ge;

  // Compare the partial remainder with the squared length, subtract, shift.
  always_comb begin
    tok_next = tok_in;
    diff     = '0;
    kept     = '0;
    ge       = 1'b0;
    for (int i = 0; i < tfn_pkg::LANES; i++) begin
      ge   = tok_in.lane[i].rem >= tfn_pkg::REM_W'(tok_in.sum_sq);
      diff = tok_in.lane[i].rem - tfn_pkg::REM_W'(tok_in.sum_sq);
      kept = ge ? diff : tok_in.lane[i].rem;
      tok_next.lane[i].rem = {kept[tfn_pkg::REM_W-2:0], 1'b0};
      tok_next.lane[i].quo = {tok_in.lane[i].quo[tfn_pkg::QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/tfn_sqrt_cell.sv =====
// One digit-by-digit integer square root step for all three lanes.
// Depends on tfn_pkg; STEP is the root bit this cell decides.
`default_nettype none

module tfn_sqrt_cell #(
  parameter int STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  tfn_pkg::sqrt_tok_t tok_in,
  output tfn_pkg::sqrt_tok_t tok_out
);

  tfn_pkg::sqrt_tok_t           tok_next;
  logic [tfn_pkg::TRIAL_W-1:0]  trial;
  logic                         fits;

  // Trial (2*root + 2^STEP) * 2^STEP against the remainder.
  always_comb begin
    tok_next = tok_in;
    trial    = '0;
    fits     = 1'b0;
    for (int i = 0; i < tfn_pkg::LANES; i++) begin
      trial = (tfn_pkg::TRIAL_W'(tok_in.lane[i].root) << (STEP + 1))
            + (tfn_pkg::TRIAL_W'(1) << (2 * STEP));
      fits  = trial <= tfn_pkg::TRIAL_W'(tok_in.lane[i].rem);
      if (fits) begin
        tok_next.lane[i].rem  = tok_in.lane[i].rem - trial[tfn_pkg::SQ_REM_W-1:0];
        tok_next.lane[i].root = tok_in.lane[i].root | (tfn_pkg::ROOT_W'(1) << STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/triangle_face_normal.sv =====
// Top level of the triangle face normal unit: front end, division and root chains.
// Depends on tfn_pkg, tfn_front, tfn_div_cell, tfn_sqrt_cell and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Takes one face (three corners, signed Q16.16) per cycle and returns its unit
// normal in signed Q1.14, rounded to nearest with ties away from zero, plus a
// degenerate flag that is set, with a zero normal, when the cross product is zero.
// The normal is exact: each component is floor((isqrt(floor(2^30 c^2 / |c|^2)) + 1) / 2)
// with the sign of the cross component. Every face passes from request to result
// through six front stages (edges, products, cross, limb products, squares, sum),
// a chain of 31 division cells, a chain of 16 square root cells and the output
// register. A new request is taken every cycle; while the result register holds
// a result that is stalled, the whole pipeline holds and face_stall is high.

module triangle_face_normal (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              face_valid,
  output logic                                   face_stall,
  input  wire logic signed [tfn_pkg::POS_W-1:0]  corner0_x,
  input  wire logic signed [tfn_pkg::POS_W-1:0]  corner0_y,
  input  wire logic signed [tfn_pkg::POS_W-1:0]  corner0_z,
  input  wire logic signed [tfn_pkg::POS_W-1:0]  corner1_x,
  input  wire logic signed [tfn_pkg::POS_W-1:0]  corner1_y,
  input  wire logic signed [tfn_pkg::POS_W-1:0]  corner1_z,
  input  wire logic signed [tfn_pkg::POS_W-1:0]  corner2_x,
  input  wire logic signed [tfn_pkg::POS_W-1:0]  corner2_y,
  input  wire logic signed [tfn_pkg::POS_W-1:0]  corner2_z,
  output logic                                   normal_valid,
  input  wire logic                              normal_stall,
  output logic signed [tfn_pkg::NORM_W-1:0]      normal_x,
  output logic signed [tfn_pkg::NORM_W-1:0]      normal_y,
  output logic signed [tfn_pkg::NORM_W-1:0]      normal_z,
  output logic                                   degenerate
);

  localparam int DIV_CELLS  = tfn_pkg::QUO_W;
  localparam int SQRT_CELLS = tfn_pkg::ROOT_W;

  logic                                en;
  tfn_pkg::div_tok_t                   div_chain  [DIV_CELLS+1];
  tfn_pkg::sqrt_tok_t                  sqrt_chain [SQRT_CELLS+1];
  logic [tfn_pkg::ROOT_W:0]            rounded    [3];
  logic signed [tfn_pkg::NORM_W-1:0]   comp_next  [3];

  // The pipeline advances unless a result waits on a stalled consumer.
  assign en         = !(normal_valid && normal_stall);
  assign face_stall = !en;

  tfn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (face_valid),
    .corner0_x (corner0_x),
    .corner0_y (corner0_y),
    .corner0_z (corner0_z),
    .corner1_x (corner1_x),
    .corner1_y (corner1_y),
    .corner1_z (corner1_z),
    .corner2_x (corner2_x),
    .corner2_y (corner2_y),
    .corner2_z (corner2_z),
    .tok_out   (div_chain[0])
  );

  // Division chain: floor(2^30 * c_i^2 / |c|^2), one quotient bit per cell.
  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    tfn_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .tok_in  (div_chain[g]),
      .tok_out (div_chain[g+1])
    );
  end

  // Hand the quotients to the root chain as its start remainders.
  always_comb begin
    sqrt_chain[0].valid = div_chain[DIV_CELLS].valid;
    sqrt_chain[0].degen = div_chain[DIV_CELLS].degen;
    sqrt_chain[0].neg   = div_chain[DIV_CELLS].neg;
    for (int i = 0; i < tfn_pkg::LANES; i++) begin
      sqrt_chain[0].lane[i].rem  = div_chain[DIV_CELLS].lane[i].quo;
      sqrt_chain[0].lane[i].root = '0;
    end
  end

  // Root chain, most significant root bit first.
  for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
    tfn_sqrt_cell #(
      .STEP (SQRT_CELLS - 1 - g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .tok_in  (sqrt_chain[g]),
      .tok_out (sqrt_chain[g+1])
    );
  end

  // Round the Q1.15 root to Q1.14 and apply the sign.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rounded[i]   = ((tfn_pkg::ROOT_W+1)'(sqrt_chain[SQRT_CELLS].lane[i].root) + 1'b1) >> 1;
      comp_next[i] = sqrt_chain[SQRT_CELLS].neg[i]
                   ? -tfn_pkg::NORM_W'(rounded[i]) : tfn_pkg::NORM_W'(rounded[i]);
      if (sqrt_chain[SQRT_CELLS].degen) begin
        comp_next[i] = '0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_valid <= 1'b0;
    end else if (en) begin
      normal_valid <= sqrt_chain[SQRT_CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal_x   <= comp_next[0];
      normal_y   <= comp_next[1];
      normal_z   <= comp_next[2];
      degenerate <= sqrt_chain[SQRT_CELLS].degen;
    end
  end

  // A degenerate face carries a zero normal.
  `ASSERT_IMPLY(a_degen_zero, normal_valid && degenerate,
    normal_x == 0 && normal_y == 0 && normal_z == 0, "degenerate face with nonzero normal")

  // A proper face never yields an all-zero normal.
  `ASSERT_IMPLY(a_nonzero_normal, normal_valid && !degenerate,
    normal_x != 0 || normal_y != 0 || normal_z != 0, "proper face with zero normal")

  // Components stay within one unit in Q1.14.
  `ASSERT_CLK(a_unit_range, !normal_valid || ((normal_x <= 16384) && (normal_x >= -16384) && (normal_y <= 16384) && (normal_y >= -16384) && (normal_z <= 16384) && (normal_z >= -16384)), "normal component out of range")

endmodule

`default_nettype wire
